[rtl/assert_macros.svh]
// Assertion macros for the RGB 3x3 median filter RTL.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define RMF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMF_ASSERT_IMP(label, ante, cons, msg)
`define RMF_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[rtl/rmf_pkg.sv]
// Shared constants, codes and types of the RGB 3x3 median filter.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
`default_nettype none

package rmf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MEDIAN_RANK = 4;
  localparam int MIN_SIZE    = 3;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int WIN_N      = 9;
  localparam int WIN_IW     = $clog2(WIN_N);
  localparam int CENTER_TAP = WIN_N / 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int EMIT_W = COL_W + ROW_W;

  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int AREA_W     = WCFG_W + HCFG_W;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam int QUEUE_DEPTH = 2;
  localparam int PIPE_N      = 3;

  localparam logic ITEM_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Channel 0 is blue, 1 green, 2 red.
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  // One emitting beat handed from the front to the sorter.
  typedef struct packed {
    win_t win;
    logic interior;
    logic frame_end;
  } job_t;

  typedef struct packed {
    logic [PIPE_N-1:0] stage_busy;
    logic              stalled;
  } bk_stat_t;

endpackage

`default_nettype wire

[rtl/rmf_if.sv]
// Stream interfaces of the RGB 3x3 median filter: pixel input and result output.
// Depends on rmf_pkg for channel widths.
`default_nettype none

interface rmf_in_if import rmf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_red;

  modport source (output valid, output kind, output in_blue, output in_green,
                  output in_red, input ready);
  modport sink   (input valid, input kind, input in_blue, input in_green,
                  input in_red, output ready);
endinterface

interface rmf_out_if import rmf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_red;
  logic            frame_end;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output frame_end, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/rmf_front.sv]
// Front end: config registers, raster counters, line store and window shift.
// Depends on rmf_pkg and rmf_in_if; feeds emitting beats to rmf_queue.
`default_nettype none

module rmf_front import rmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rmf_in_if.sink                in_px,
  output logic                  q_valid,
  input  logic                  q_ready,
  output job_t                  q_job
);

  localparam int XC_W = (COL_W + 1 > WCFG_W) ? COL_W + 1 : WCFG_W;
  localparam int RC_W = (ROW_W + 1 > HCFG_W) ? ROW_W + 1 : HCFG_W;
  localparam int EC_W = (EMIT_W + 1 > AREA_W) ? EMIT_W + 1 : AREA_W;

  typedef struct packed {
    pix_t newer;
    pix_t older;
  } line_word_t;

  function automatic logic [WCFG_W-1:0] clamp_width(input logic [WCFG_W-1:0] v);
    logic [WCFG_W-1:0] r;
    r = v;
    if (v < WCFG_W'(MIN_SIZE)) r = WCFG_W'(MIN_SIZE);
    else if (int'(v) > MAX_WIDTH) r = WCFG_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [HCFG_W-1:0] clamp_height(input logic [HCFG_W-1:0] v);
    logic [HCFG_W-1:0] r;
    r = v;
    if (v < HCFG_W'(MIN_SIZE)) r = HCFG_W'(MIN_SIZE);
    else if (int'(v) > MAX_HEIGHT) r = HCFG_W'(MAX_HEIGHT);
    return r;
  endfunction

  // configuration
  logic [WCFG_W-1:0] width_r, w_used, mul_w;
  logic [HCFG_W-1:0] height_r, h_used, mul_h;
  logic [AREA_W-1:0] area_r, area_nxt;
  logic              cfg_sel_w, cfg_sel_h;

  // raster state
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [EMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic              done_r, done_nxt;

  // classification
  logic              in_ready, ignored, load, flushing;
  logic [XC_W-1:0]   x_inc;
  logic [RC_W-1:0]   row_inc;
  logic [EC_W-1:0]   emit_inc;
  logic              col_end, row_end, emit, interior, frame_end;
  pix_t              in_pix;

  // read stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]  s1_x_r;
  pix_t              s1_cur_r;
  logic              s1_emit_r, s1_interior_r, s1_end_r;
  logic              s2_fire;

  // line store and window
  line_word_t        line_mem [MAX_WIDTH];
  line_word_t        line_rd_r, line_eff, byp_word_r, byp_word_nxt;
  logic              byp_r, byp_nxt;
  win_t              win_r, win_nxt;

  always_comb begin
    w_used    = clamp_width(width_r);
    h_used    = clamp_height(height_r);
    cfg_sel_w = cfg_we && (cfg_index == REG_IMAGE_WIDTH);
    cfg_sel_h = cfg_we && (cfg_index == REG_IMAGE_HEIGHT);
    mul_w     = cfg_sel_w ? clamp_width(cfg_data[WCFG_W-1:0]) : w_used;
    mul_h     = cfg_sel_h ? clamp_height(cfg_data[HCFG_W-1:0]) : h_used;
    area_nxt  = AREA_W'(mul_w) * AREA_W'(mul_h);
  end

  always_comb begin
    in_pix[0] = in_px.in_blue;
    in_pix[1] = in_px.in_green;
    in_pix[2] = in_px.in_red;

    flushing = done_r;
    ignored  = !done_r && (in_px.kind == ITEM_FLUSH);
    s2_fire  = s1_valid_r && (!s1_emit_r || q_ready);
    in_ready = !s1_valid_r || s2_fire;
    load     = in_px.valid && in_ready && !ignored;

    x_inc    = XC_W'(col_r) + XC_W'(1);
    row_inc  = RC_W'(row_r) + RC_W'(1);
    emit_inc = EC_W'(emit_cnt_r) + EC_W'(1);
    col_end  = x_inc >= XC_W'(w_used);
    row_end  = row_inc >= RC_W'(h_used);

    emit = flushing || (row_r >= ROW_W'(2)) ||
           ((row_r == ROW_W'(1)) && (col_r != '0));
    interior = !flushing && (row_r >= ROW_W'(2)) && (row_inc <= RC_W'(h_used)) &&
               (col_r >= COL_W'(2)) && (x_inc <= XC_W'(w_used));
    frame_end = emit_inc >= EC_W'(area_r);
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    emit_cnt_nxt = emit_cnt_r;
    done_nxt     = done_r;
    if (load) begin
      col_nxt = col_end ? '0 : x_inc[COL_W-1:0];
      if (col_end && !flushing) begin
        if (row_end) begin
          done_nxt = 1'b1;
          row_nxt  = '0;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end
      if (emit) begin
        if (frame_end) begin
          col_nxt      = '0;
          row_nxt      = '0;
          emit_cnt_nxt = '0;
          done_nxt     = 1'b0;
        end else begin
          emit_cnt_nxt = emit_inc[EMIT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) s1_valid_nxt = 1'b1;
    else if (s2_fire) s1_valid_nxt = 1'b0;

    // A read that lands on the column being written this edge sees stale data.
    line_eff = byp_r ? byp_word_r : line_rd_r;
    byp_nxt  = s2_fire && (col_r == s1_x_r);
    byp_word_nxt.newer = s1_cur_r;
    byp_word_nxt.older = line_eff.newer;

    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = win_r[i*3+1];
      win_nxt[i*3 + 1] = win_r[i*3+2];
    end
    win_nxt[2] = line_eff.older;
    win_nxt[5] = line_eff.newer;
    win_nxt[8] = s1_cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WCFG_W'(WIDTH_RESET);
      height_r   <= HCFG_W'(HEIGHT_RESET);
      area_r     <= AREA_W'(WIDTH_RESET * HEIGHT_RESET);
      col_r      <= '0;
      row_r      <= '0;
      emit_cnt_r <= '0;
      done_r     <= 1'b0;
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      win_r      <= '0;
    end else begin
      if (cfg_sel_w) width_r <= cfg_data[WCFG_W-1:0];
      if (cfg_sel_h) height_r <= cfg_data[HCFG_W-1:0];
      if (cfg_we) area_r <= area_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      done_r     <= done_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (load) byp_r <= byp_nxt;
      if (s2_fire) win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_x_r        <= col_r;
      s1_cur_r      <= flushing ? '0 : in_pix;
      s1_emit_r     <= emit;
      s1_interior_r <= interior;
      s1_end_r      <= frame_end;
      byp_word_r    <= byp_word_nxt;
    end
  end

  // Line store: read at accept, write back when the item leaves the read stage.
  always_ff @(posedge clk) begin
    if (load) line_rd_r <= line_mem[col_r];
    if (s2_fire) line_mem[s1_x_r] <= byp_word_nxt;
  end

  assign in_px.ready     = in_ready;
  assign q_valid         = s1_valid_r && s1_emit_r;
  assign q_job.win       = win_nxt;
  assign q_job.interior  = s1_interior_r;
  assign q_job.frame_end = s1_end_r;

endmodule

`default_nettype wire

[rtl/rmf_queue.sv]
// Short queue that decouples the front end from the sorting pipeline.
// Depends on rmf_pkg for job_t and QUEUE_DEPTH.
`default_nettype none

module rmf_queue import rmf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign push_ready = count_r < CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = q_mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/rmf_back.sv]
// Back end: pipelined median-of-nine sorting network per channel and output register.
// Depends on rmf_pkg and rmf_out_if; takes beats from rmf_queue.
`default_nettype none

module rmf_back import rmf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  job_t     q_job,
  rmf_out_if.source out_px,
  output bk_stat_t stat
);

  typedef logic [WIN_N-1:0][CH_W-1:0] chan_win_t;

  typedef struct packed {
    chan_win_t [NUM_CH-1:0] ch;
    pix_t                   center;
    logic                   interior;
    logic                   frame_end;
  } slot_t;

  // Compare-exchange: the first index of the pair ends with the minimum.
  function automatic chan_win_t cas(input chan_win_t v, input logic [WIN_IW-1:0] a,
                                    input logic [WIN_IW-1:0] b);
    chan_win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  function automatic slot_t stage_a(input slot_t s);
    slot_t r;
    r = s;
    for (int c = 0; c < NUM_CH; c++) begin
      r.ch[c] = cas(r.ch[c], WIN_IW'(1), WIN_IW'(2));
      r.ch[c] = cas(r.ch[c], WIN_IW'(4), WIN_IW'(5));
      r.ch[c] = cas(r.ch[c], WIN_IW'(7), WIN_IW'(8));
      r.ch[c] = cas(r.ch[c], WIN_IW'(0), WIN_IW'(1));
      r.ch[c] = cas(r.ch[c], WIN_IW'(3), WIN_IW'(4));
      r.ch[c] = cas(r.ch[c], WIN_IW'(6), WIN_IW'(7));
    end
    return r;
  endfunction

  function automatic slot_t stage_b(input slot_t s);
    slot_t r;
    r = s;
    for (int c = 0; c < NUM_CH; c++) begin
      r.ch[c] = cas(r.ch[c], WIN_IW'(1), WIN_IW'(2));
      r.ch[c] = cas(r.ch[c], WIN_IW'(4), WIN_IW'(5));
      r.ch[c] = cas(r.ch[c], WIN_IW'(7), WIN_IW'(8));
      r.ch[c] = cas(r.ch[c], WIN_IW'(0), WIN_IW'(3));
      r.ch[c] = cas(r.ch[c], WIN_IW'(5), WIN_IW'(8));
      r.ch[c] = cas(r.ch[c], WIN_IW'(4), WIN_IW'(7));
    end
    return r;
  endfunction

  function automatic slot_t stage_c(input slot_t s);
    slot_t r;
    r = s;
    for (int c = 0; c < NUM_CH; c++) begin
      r.ch[c] = cas(r.ch[c], WIN_IW'(3), WIN_IW'(6));
      r.ch[c] = cas(r.ch[c], WIN_IW'(1), WIN_IW'(4));
      r.ch[c] = cas(r.ch[c], WIN_IW'(2), WIN_IW'(5));
      r.ch[c] = cas(r.ch[c], WIN_IW'(4), WIN_IW'(7));
    end
    return r;
  endfunction

  function automatic slot_t stage_d(input slot_t s);
    slot_t r;
    r = s;
    for (int c = 0; c < NUM_CH; c++) begin
      r.ch[c] = cas(r.ch[c], WIN_IW'(4), WIN_IW'(2));
      r.ch[c] = cas(r.ch[c], WIN_IW'(6), WIN_IW'(4));
      r.ch[c] = cas(r.ch[c], WIN_IW'(4), WIN_IW'(2));
    end
    return r;
  endfunction

  slot_t             a_in, fin;
  slot_t             p_r [PIPE_N];
  logic [PIPE_N-1:0] busy_r;
  logic              adv;
  pix_t              res;
  pix_t              out_pix_r;
  logic              out_end_r, out_valid_r;

  always_comb begin
    for (int k = 0; k < WIN_N; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        a_in.ch[c][k] = q_job.win[k][c];
      end
    end
    a_in.center    = q_job.win[CENTER_TAP];
    a_in.interior  = q_job.interior;
    a_in.frame_end = q_job.frame_end;

    fin = stage_d(p_r[PIPE_N-1]);
    for (int c = 0; c < NUM_CH; c++) begin
      res[c] = fin.interior ? fin.ch[c][MEDIAN_RANK] : fin.center[c];
    end

    adv = !out_valid_r || out_px.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      busy_r      <= {busy_r[PIPE_N-2:0], q_valid};
      out_valid_r <= busy_r[PIPE_N-1];
    end
  end

  // Advance the whole pipe together; hold everything while the sink stalls.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0]    <= stage_a(a_in);
      p_r[1]    <= stage_b(p_r[0]);
      p_r[2]    <= stage_c(p_r[1]);
      out_pix_r <= res;
      out_end_r <= fin.frame_end;
    end
  end

  assign q_ready          = adv;
  assign out_px.valid     = out_valid_r;
  assign out_px.out_blue  = out_pix_r[0];
  assign out_px.out_green = out_pix_r[1];
  assign out_px.out_red   = out_pix_r[2];
  assign out_px.frame_end = out_end_r;
  assign stat.stage_busy  = busy_r;
  assign stat.stalled     = !adv;

endmodule

`default_nettype wire

[rtl/rgb_median_filter_3x3.sv]
// Top level of the streaming RGB 3x3 median filter.
// Depends on rmf_pkg, rmf_if, rmf_front, rmf_queue, rmf_back and assert_macros.svh.
//
//   port group | direction | beat contents
//   -----------+-----------+-------------------------------------------------
//   in_px      | sink      | kind, in_blue, in_green, in_red
//   out_px     | source    | out_blue, out_green, out_red, frame_end
//   cfg_*      | write     | cfg_index selects image_width / image_height
//
// Throughput is one beat per clock in both directions while out_px is not stalled;
// the limit is the single line store port pair and the one-beat-per-cycle sorter.
// An accepted beat reaches out_px through the read stage, the queue, three sorter
// stages and the output register. Reset is synchronous; there is no clearing pass
// and the line store contents are undefined until a frame writes them. A stalled
// output freezes the sorter and fills the queue before in_px.ready drops.
`default_nettype none
`include "assert_macros.svh"

module rgb_median_filter_3x3 import rmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rmf_in_if.sink                in_px,
  rmf_out_if.source             out_px
);

  // front -> queue
  logic     q_push_valid, q_push_ready;
  job_t     q_push_data;
  // queue -> sorter
  logic     q_pop_valid, q_pop_ready;
  job_t     q_pop_data;
  bk_stat_t bk_stat;

  // Classify beats, track raster position, keep two rows and the 3x3 window.
  rmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_px     (in_px),
    .q_valid   (q_push_valid),
    .q_ready   (q_push_ready),
    .q_job     (q_push_data)
  );

  // Absorb the gap between a front that must hold and a sorter that stalls.
  rmf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // Sort each channel, pick median or pass the center through, register it.
  rmf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_pop_valid),
    .q_ready (q_pop_ready),
    .q_job   (q_pop_data),
    .out_px  (out_px),
    .stat    (bk_stat)
  );

  // Input only backs up when an emitting beat is blocked at a full queue.
  `RMF_ASSERT_IMP(a_in_stall_cause, !in_px.ready, q_push_valid && !q_push_ready, "input stalled without a full queue")
  // The queue never shows data it was not given.
  `RMF_ASSERT_IMP(a_queue_from_push, $rose(q_pop_valid), $past(q_push_valid && q_push_ready), "queue became non-empty without a push")
  // A result appears only after leaving the last sorter stage.
  `RMF_ASSERT_IMP(a_out_from_pipe, $rose(out_px.valid), $past(bk_stat.stage_busy[PIPE_N-1]), "result without a sorter beat")
  // A stalled sorter keeps its occupancy.
  `RMF_ASSERT_NXT(a_stall_freezes, bk_stat.stalled, $stable(bk_stat.stage_busy), "sorter moved while stalled")

endmodule

`default_nettype wire
